// ===== rtl/pec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pec_pkg;

    // job queue between front and back
    localparam int JOB_FIFO_DEPTH = 4;
    localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);
    localparam int JOB_CNT_W      = $clog2(JOB_FIFO_DEPTH + 1);

    // characters
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_CHAR = 2'd1,
        ERR_OPEN_END = 2'd2
    } err_code_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    typedef enum logic {
        JOB_SINGLE = 1'b0,   // one result word
        JOB_TRIPLE = 1'b1    // '%' plus two hex digits
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
        err_code_t  err;
        logic       last;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } digit_t;

    function automatic digit_t digit_value(input logic [7:0] c);
        digit_t d;
        d.valid = 1'b1;
        d.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
            d.value = 6'(c - 8'h41) + 6'd10;
        else if (c >= 8'h61 && c <= 8'h7A)
            d.value = 6'(c - 8'h61) + 6'd10;
        else if (c >= 8'h30 && c <= 8'h39)
            d.value = 6'(c - 8'h30);
        else
            d.valid = 1'b0;
        return d;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib > 4'd9) ? ({4'h0, nib} + 8'd55) : ({4'h0, nib} + 8'd48);
    endfunction

    function automatic logic passes_plain(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_MINUS || c == CH_UNDER ||
               c == CH_DOT || c == CH_TILDE;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pec_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pec_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          string_last,
    input  wire logic          direction,
    input  wire logic          dir_write,
    output logic               job_push,
    output pec_pkg::job_t      job
);
    import pec_pkg::*;

    esc_phase_t esc_reg, esc_next;
    logic [5:0] high_reg, high_next;
    digit_t     dig;
    logic       in_esc;

    assign dig    = digit_value(in_byte);
    assign in_esc = (esc_reg == ESC_HIGH) || (esc_reg == ESC_LOW);

    // next escape state
    always_comb
    begin
        esc_next  = esc_reg;
        high_next = high_reg;
        if (dir_write)
        begin
            esc_next  = ESC_IDLE;
            high_next = 6'd0;
        end
        else if (accept && direction)
        begin
            case (esc_reg)
                ESC_HIGH:
                begin
                    if (dig.valid)
                    begin
                        high_next = dig.value;
                        esc_next  = ESC_LOW;
                    end
                    else
                        esc_next = ESC_IDLE;
                end
                ESC_LOW:
                    esc_next = ESC_IDLE;
                default:
                    esc_next = (in_byte == CH_PERCENT) ? ESC_HIGH : ESC_IDLE;
            endcase
            if (string_last)
            begin
                esc_next  = ESC_IDLE;
                high_next = 6'd0;
            end
        end
    end

    // classify into a job
    always_comb
    begin
        job.kind = JOB_SINGLE;
        job.data = in_byte;
        job.err  = ERR_NONE;
        job.last = string_last;
        job_push = accept;
        if (!direction)
        begin
            if (passes_plain(in_byte))
                job.data = in_byte;
            else if (in_byte == CH_SPACE)
                job.data = CH_PLUS;
            else
                job.kind = JOB_TRIPLE;
        end
        else if (in_esc)
        begin
            if (!dig.valid)
            begin
                job.data = 8'd0;
                job.err  = ERR_BAD_CHAR;
            end
            else if (esc_reg == ESC_HIGH)
            begin
                job.data = 8'd0;
                job.err  = ERR_OPEN_END;
                job_push = accept && string_last;
            end
            else
                job.data = {high_reg[3:0], 4'h0} + {2'b00, dig.value};
        end
        else if (in_byte == CH_PLUS)
            job.data = CH_SPACE;
        else if (in_byte == CH_PERCENT)
        begin
            job.data = 8'd0;
            job.err  = ERR_OPEN_END;
            job_push = accept && string_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= ESC_IDLE;
            high_reg <= 6'd0;
        end
        else
        begin
            esc_reg  <= esc_next;
            high_reg <= high_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pec_job_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pec_job_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire pec_pkg::job_t wr_job,
    output logic               full,
    input  wire logic          rd_en,
    output pec_pkg::job_t      rd_job,
    output logic               empty
);
    import pec_pkg::*;

    job_t                 slot_reg [JOB_FIFO_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [JOB_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 do_wr, do_rd;

    assign full   = (cnt_reg == JOB_CNT_W'(JOB_FIFO_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == JOB_PTR_W'(JOB_FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == JOB_PTR_W'(JOB_FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pec_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pec_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pec_pkg::job_t head_job,
    input  wire logic          head_empty,
    output logic               head_pop,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               string_end,
    output logic [1:0]         fault_code
);
    import pec_pkg::*;

    job_t       cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       run_last_reg, str_end_reg;
    err_code_t  err_reg;

    logic       advance, cur_final, load;
    logic [7:0] piece;

    assign cur_final = (cur_reg.kind == JOB_SINGLE) || (idx_reg == 2'd2);
    assign advance   = cur_valid_reg && (!out_valid_reg || pop);
    assign load      = !cur_valid_reg || (advance && cur_final);
    assign head_pop  = load && !head_empty;

    always_comb
    begin
        piece = cur_reg.data;
        if (cur_reg.kind == JOB_TRIPLE)
        begin
            case (idx_reg)
                2'd0:    piece = CH_PERCENT;
                2'd1:    piece = hex_char(cur_reg.data[7:4]);
                default: piece = hex_char(cur_reg.data[3:0]);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
            cur_reg <= head_job;
        if (advance)
        begin
            byte_reg     <= piece;
            run_last_reg <= cur_final;
            str_end_reg  <= cur_final && cur_reg.last;
            err_reg      <= cur_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= !head_empty;
                idx_reg       <= 2'd0;
            end
            else if (advance)
                idx_reg <= idx_reg + 2'd1;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty      = !out_valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = run_last_reg;
    assign string_end = str_end_reg;
    assign fault_code = err_reg;

endmodule

`default_nettype wire

// ===== rtl/percent_encoding_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+---------------------------
// input    | in_byte[7:0], string_last                    | push, taken when !full
// result   | out_byte[7:0], run_last, string_end,         | word shown while !empty,
//          | fault_code[1:0]                              | taken on pop
// config   | direction                                    | direction_we, no wait
//
// The back end emits one result word per cycle while results are popped, so an
// encoded escape gives three result words and any other word at most one (output port bound).
// Before it is shown, a result word passes the job queue, the job register and
// the output register.
// rst_n clears the escape state, the job queue and the output valid flag.
// A 4-deep job queue lets the input side keep taking words while results stall.

module percent_encoding_codec (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input word
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       string_last,
    // result word
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            string_end,
    output logic [1:0]      fault_code,
    // configuration
    input  wire logic       direction_we,
    input  wire logic       direction
);
    import pec_pkg::*;

    logic direction_reg;
    logic accept;
    logic job_push;
    job_t front_job;
    job_t head_job;
    logic head_empty;
    logic head_pop;

    // 0 encodes, 1 decodes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direction_reg <= 1'b0;
        else if (direction_we)
            direction_reg <= direction;
    end

    assign accept = push && !full;

    // front: classify the byte, track the escape, queue a job when it yields output
    pec_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .string_last (string_last),
        .direction   (direction_reg),
        .dir_write   (direction_we),
        .job_push    (job_push),
        .job         (front_job)
    );

    // full reflects the queue only; a word that yields no job still needs a slot free
    pec_job_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (front_job),
        .full   (full),
        .rd_en  (head_pop),
        .rd_job (head_job),
        .empty  (head_empty)
    );

    // back: expand jobs into one result word per cycle while results are popped
    pec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end),
        .fault_code (fault_code)
    );

endmodule

`default_nettype wire

// ===== bench/tb_percent_encoding_codec.sv =====
`timescale 1ns / 1ps

import pec_pkg::*;

// One result word as the block should present it.
typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_end;
    err_code_t  err;
} result_word_t;

// Tracks the codec state (direction, escape progress, high digit) and holds
// the result words still owed by the block, oldest first.
class codec_scoreboard;
    logic         dir;
    esc_phase_t   phase;
    logic [5:0]   hi_digit;
    result_word_t owed_q[$];
    int           fails;

    function new();
        dir      = 1'b0;
        phase    = ESC_IDLE;
        hi_digit = 6'd0;
        fails    = 0;
    endfunction

    // Any direction write drops a half-read escape.
    function void set_direction(logic d);
        dir      = d;
        phase    = ESC_IDLE;
        hi_digit = 6'd0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // 0-9 -> 0..9, A-Z and a-z -> 10..35, anything else -> -1
    function int digit_of(logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return int'(c) - 55;
        if (c >= "a" && c <= "z")
            return int'(c) - 87;
        if (c >= "0" && c <= "9")
            return int'(c) - 48;
        return -1;
    endfunction

    function logic [7:0] hex_ascii(logic [3:0] nib);
        return (nib > 4'd9) ? 8'(nib) + 8'd55 : 8'(nib) + 8'd48;
    endfunction

    function logic unreserved(logic [7:0] c);
        return digit_of(c) >= 0 || c == CH_MINUS || c == CH_UNDER ||
               c == CH_DOT || c == CH_TILDE;
    endfunction

    // Works out the result words caused by one accepted input word.
    function void note_word(logic [7:0] c, logic last);
        result_word_t run_q[$];
        result_word_t w;
        int           d;
        w = '{data: 8'h00, run_last: 1'b0, str_end: 1'b0, err: ERR_NONE};
        if (!dir) begin
            if (unreserved(c)) begin
                w.data = c;
                run_q.push_back(w);
            end else if (c == CH_SPACE) begin
                w.data = CH_PLUS;
                run_q.push_back(w);
            end else begin
                w.data = CH_PERCENT;
                run_q.push_back(w);
                w.data = hex_ascii(c[7:4]);
                run_q.push_back(w);
                w.data = hex_ascii(c[3:0]);
                run_q.push_back(w);
            end
        end else begin
            case (phase)
                ESC_HIGH, ESC_LOW: begin
                    d = digit_of(c);
                    if (d < 0) begin
                        w.err = ERR_BAD_CHAR;
                        run_q.push_back(w);
                        phase = ESC_IDLE;
                    end else if (phase == ESC_HIGH) begin
                        hi_digit = 6'(d);
                        phase    = ESC_LOW;
                        if (last) begin
                            w.err = ERR_OPEN_END;
                            run_q.push_back(w);
                        end
                    end else begin
                        w.data = 8'((int'(hi_digit) * 16 + d) & 255);
                        run_q.push_back(w);
                        phase = ESC_IDLE;
                    end
                end
                default: begin
                    phase = ESC_IDLE;
                    if (c == CH_PLUS) begin
                        w.data = CH_SPACE;
                        run_q.push_back(w);
                    end else if (c == CH_PERCENT) begin
                        phase = ESC_HIGH;
                        if (last) begin
                            w.err = ERR_OPEN_END;
                            run_q.push_back(w);
                        end
                    end else begin
                        w.data = c;
                        run_q.push_back(w);
                    end
                end
            endcase
            if (last) begin
                phase    = ESC_IDLE;
                hi_digit = 6'd0;
            end
        end
        if (run_q.size() > 0) begin
            run_q[run_q.size() - 1].run_last = 1'b1;
            run_q[run_q.size() - 1].str_end  = last;
        end
        foreach (run_q[i])
            owed_q.push_back(run_q[i]);
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        fails++;
    endtask

    task check_word(logic [7:0] b, logic rl, logic se, logic [1:0] ec);
        result_word_t w;
        if (owed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word byte=%h run_last=%b end=%b err=%0d",
                                      b, rl, se, ec));
        end else begin
            w = owed_q.pop_front();
            if (b !== w.data)
                report_mismatch($sformatf("out_byte %h, want %h", b, w.data));
            if (rl !== w.run_last)
                report_mismatch($sformatf("run_last %b, want %b (byte %h)",
                                          rl, w.run_last, w.data));
            if (se !== w.str_end)
                report_mismatch($sformatf("string_end %b, want %b (byte %h)",
                                          se, w.str_end, w.data));
            if (ec !== w.err)
                report_mismatch($sformatf("fault_code %0d, want %0d (byte %h)",
                                          ec, w.err, w.data));
        end
    endtask
endclass

module tb_percent_encoding_codec;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 9;
    // Quiet spell ahead of a register write.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    // Longest legal quiet spell is a settle pause or a run of sender gaps or receiver stalls.
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 12;
    localparam int NUM_PHASES    = 8;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       push         = 1'b0;
    logic [7:0] in_byte      = 8'h00;
    logic       string_last  = 1'b0;
    logic       pop          = 1'b0;
    logic       direction_we = 1'b0;
    logic       direction    = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic [1:0] fault_code;

    // percent chance per cycle of a sender gap / receiver stall
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int quiet_cycles   = 0;

    codec_scoreboard sb = new();

    percent_encoding_codec dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .string_last (string_last),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_end  (string_end),
        .fault_code  (fault_code),
        .direction_we(direction_we),
        .direction   (direction)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Result side: check the word taken at this edge (pre-edge values), then
    // pick pop for the next edge. pop gets exactly one NBA per edge.
    always @(posedge clk) begin
        if (rst_n && pop && !empty)
            sb.check_word(out_byte, run_last, string_end, fault_code);
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: any cycle with no word moving on either side counts.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offer one input word, with random gaps ahead of it, and hold it until
    // the block takes it. push is left high; the next call either reuses it
    // or drops it, never both in one step.
    task automatic send_word(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        in_byte     <= b;
        string_last <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_word(b, l);
        words_sent++;
    endtask

    // Sender holds off until every owed result word has come out; always
    // steps past a clock edge before it checks, so push is never driven twice in one step.
    task automatic drain_outputs();
        push <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Register writes only on an idle block: drained, then a settle pause.
    task automatic write_direction(input logic d);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        direction_we <= 1'b1;
        direction    <= d;
        @(posedge clk);
        direction_we <= 1'b0;
        sb.set_direction(d);
    endtask

    function automatic logic [7:0] pick_digit_char();
        int v;
        v = $urandom_range(0, 61);
        if (v < 10)
            return 8'(48 + v);
        if (v < 36)
            return 8'(55 + v);
        return 8'(61 + v);
    endfunction

    function automatic logic [7:0] pick_bad_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (sb.digit_of(c) >= 0)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic coin_last();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // Encode: raw bytes over the full range, pass-through chars and spaces.
    task automatic rand_encode_word();
        int kind;
        int pick;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 4);
        if (kind < 50)
            send_word(8'($urandom_range(0, 255)), coin_last());
        else if (kind < 80)
            case (pick)
                0: send_word(CH_MINUS, coin_last());
                1: send_word(CH_UNDER, coin_last());
                2: send_word(CH_DOT, coin_last());
                3: send_word(CH_TILDE, coin_last());
                default: send_word(pick_digit_char(), coin_last());
            endcase
        else
            send_word(CH_SPACE, coin_last());
    endtask

    // Decode: complete escapes with random digits most often, plus '+', noise,
    // broken escapes and strings that stop inside an escape.
    task automatic rand_decode_run();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            send_word(CH_PERCENT, 1'b0);
            send_word(pick_digit_char(), 1'b0);
            send_word(pick_digit_char(), coin_last());
        end else if (kind < 60) begin
            send_word(CH_PLUS, coin_last());
        end else if (kind < 78) begin
            send_word(8'($urandom_range(0, 255)), coin_last());
        end else if (kind < 90) begin
            send_word(CH_PERCENT, 1'b0);
            if ($urandom_range(0, 1))
                send_word(pick_digit_char(), 1'b0);
            send_word(pick_bad_char(), coin_last());
        end else if ($urandom_range(0, 1)) begin
            send_word(CH_PERCENT, 1'b0);
            send_word(pick_digit_char(), 1'b1);
        end else begin
            send_word(CH_PERCENT, 1'b1);
        end
    endtask

    initial begin
        int phase_start;
        logic dir;
        bit mid_drained;

        mid_drained = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: encode from the reset direction ---
        send_word("A", 1'b0);
        send_word("z", 1'b0);
        send_word("9", 1'b0);
        send_word(CH_MINUS, 1'b0);
        send_word(CH_UNDER, 1'b0);
        send_word(CH_DOT, 1'b0);
        send_word(CH_TILDE, 1'b0);
        send_word(CH_SPACE, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_PERCENT, 1'b1);

        // --- directed: decode ---
        write_direction(1'b1);
        send_word(CH_PLUS, 1'b0);
        // top digits: 35*16+35 wraps modulo 256
        send_word(CH_PERCENT, 1'b0);
        send_word("z", 1'b0);
        send_word("Z", 1'b0);
        // bad low digit
        send_word(CH_PERCENT, 1'b0);
        send_word("4", 1'b0);
        send_word("#", 1'b0);
        // string stops right after the opener, then after the high digit
        send_word(CH_PERCENT, 1'b1);
        send_word(CH_PERCENT, 1'b0);
        send_word("7", 1'b1);
        // bad high digit on the final byte still flags string_end
        send_word(CH_PERCENT, 1'b0);
        send_word("@", 1'b1);
        // a direction write, even to the same value, drops an open escape:
        // "41" afterwards must pass through as plain text
        send_word(CH_PERCENT, 1'b0);
        write_direction(1'b1);
        send_word("4", 1'b0);
        send_word("1", 1'b1);

        // --- random phases: every idling mode meets both directions ---
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            dir = 1'(ph) ^ 1'(ph >> 2);
            write_direction(dir);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                if (ph == 4 && !mid_drained &&
                    words_sent - phase_start >= PHASE_WORDS / 2) begin
                    drain_outputs();
                    mid_drained = 1'b1;
                end
                if (dir)
                    rand_decode_run();
                else
                    rand_encode_word();
            end
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d result words never came", sb.pending()));

        if (sb.fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
